// ===== hw/rtl/mfr_pkg.sv =====
// shared constants and types for the meter frame ratio decoder
package mfr_pkg;

  localparam int BYTE_W      = 8;
  localparam int WORD_W      = 24;
  localparam int RATIO_W     = 40;
  localparam int MAX_QUOT_W  = 48;
  localparam int STORE_BYTES = 18;
  localparam int STORE_W     = STORE_BYTES * BYTE_W;
  localparam int CAPTURE_LEN = 22;
  localparam int POS_W       = 5;
  localparam int Q_DEPTH     = 2;
  localparam int NUM_CH      = 3;

  localparam logic [BYTE_W-1:0]  SYNC_FIRST  = 8'h55;
  localparam logic [BYTE_W-1:0]  SYNC_SECOND = 8'h5A;
  localparam logic [RATIO_W-1:0] RATIO_SAT   = '1;

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_SYNC2   = 2'd1,
    PH_CAPTURE = 2'd2
  } hunt_phase_t;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_RUN  = 2'd1,
    BK_DONE = 2'd2
  } back_state_t;

  // frame bytes 2..19 in arrival order, first byte at the top
  typedef struct packed {
    logic [WORD_W-1:0] vnum;
    logic [WORD_W-1:0] vden;
    logic [WORD_W-1:0] inum;
    logic [WORD_W-1:0] iden;
    logic [WORD_W-1:0] pnum;
    logic [WORD_W-1:0] pden;
  } meas_job_t;

  // handshake between a producer and consumer of jobs
  typedef struct packed {
    logic valid;
    logic ready;
  } job_hs_t;

endpackage

// ===== hw/rtl/mfr_byte_if.sv =====
// byte stream channel from the serial receiver
interface mfr_byte_if import mfr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== hw/rtl/mfr_result_if.sv =====
// result channel carrying the three measurement ratios
interface mfr_result_if import mfr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [RATIO_W-1:0] voltage_ratio;
  logic [RATIO_W-1:0] current_ratio;
  logic [RATIO_W-1:0] power_ratio;
  logic               voltage_den_zero;
  logic               current_den_zero;
  logic               power_den_zero;

  modport source (
    output valid, output voltage_ratio, output current_ratio, output power_ratio,
    output voltage_den_zero, output current_den_zero, output power_den_zero,
    input ready
  );
  modport sink (
    input valid, input voltage_ratio, input current_ratio, input power_ratio,
    input voltage_den_zero, input current_den_zero, input power_den_zero,
    output ready
  );
endinterface

// ===== hw/rtl/mfr_front.sv =====
// frame parser: sync hunt, byte capture and job hand-off
module mfr_front import mfr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  mfr_byte_if.sink  rx,
  output logic      push,
  output meas_job_t job,
  input  logic      q_full
);

  hunt_phase_t        phase, phase_next;
  logic [POS_W-1:0]   pos, pos_next;
  logic [STORE_W-1:0] store;
  logic               accept;
  logic               last;

  assign last   = (pos >= POS_W'(CAPTURE_LEN - 1));
  assign accept = rx.valid && rx.ready;
  assign job    = meas_job_t'(store);

  // only the closing beat needs room in the queue
  assign rx.ready = !((phase == PH_CAPTURE) && last && q_full);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HUNT;
      pos   <= '0;
    end else begin
      phase <= phase_next;
      pos   <= pos_next;
    end
  end

  always_comb begin
    phase_next = phase;
    pos_next   = pos;
    push       = 1'b0;
    if (accept) begin
      case (phase)
        PH_SYNC2: begin
          phase_next = (rx.rx_byte == SYNC_SECOND) ? PH_CAPTURE : PH_HUNT;
          pos_next   = '0;
        end
        PH_CAPTURE: begin
          if (last) begin
            push       = 1'b1;
            phase_next = PH_HUNT;
            pos_next   = '0;
          end else begin
            pos_next = pos + POS_W'(1);
          end
        end
        default: begin
          phase_next = (rx.rx_byte == SYNC_FIRST) ? PH_SYNC2 : PH_HUNT;
          pos_next   = '0;
        end
      endcase
    end
  end

  // payload bytes shift in; checksum bytes are only counted
  always_ff @(posedge clk) begin
    if (accept && (phase == PH_CAPTURE) && (pos < POS_W'(STORE_BYTES))) begin
      store <= {store[STORE_W-BYTE_W-1:0], rx.rx_byte};
    end
  end

endmodule

// ===== hw/rtl/mfr_queue.sv =====
// two-entry job queue between the parser and the divider
module mfr_queue import mfr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  meas_job_t job_in,
  output logic      full,
  output job_hs_t   hs,
  input  logic      pop_ready,
  output meas_job_t job_out
);

  localparam int PTR_W = $clog2(Q_DEPTH);
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  meas_job_t        mem [Q_DEPTH];
  logic [PTR_W-1:0] wptr, rptr;
  logic [CNT_W-1:0] count;
  logic             pop;

  assign full     = (count == CNT_W'(Q_DEPTH));
  assign hs.valid = (count != '0);
  assign hs.ready = pop_ready;
  assign pop      = hs.valid && pop_ready;
  assign job_out  = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + PTR_W'(1);
      if (pop) rptr <= rptr + PTR_W'(1);
      if (push && !pop) count <= count + CNT_W'(1);
      else if (pop && !push) count <= count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= job_in;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("job pushed into a full queue");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(Q_DEPTH))
    else $error("queue count out of range");

endmodule

// ===== hw/rtl/mfr_back.sv =====
// shared restoring divider for the three ratios and the result register
module mfr_back import mfr_pkg::*; #(
  parameter int FRACTION_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  job_hs_t      hs,
  output logic         job_ready,
  input  meas_job_t    job_in,
  mfr_result_if.source meas
);

  localparam int QUOT_W = WORD_W + FRACTION_BITS;
  localparam int CNT_W  = $clog2(QUOT_W);
  localparam int CH_W   = $clog2(NUM_CH);

  back_state_t         state, state_next;
  meas_job_t           job;
  logic [CH_W-1:0]     ch;
  logic [CNT_W-1:0]    cnt;
  logic [WORD_W-1:0]   rem, rem_step;
  logic [QUOT_W-1:0]   dvd, quot, quot_step;
  logic [RATIO_W-1:0]  res_ratio [NUM_CH];
  logic                res_zero  [NUM_CH];
  logic [WORD_W-1:0]   num_next, den;
  logic [WORD_W:0]     trial, diff;
  logic                ge;
  logic [MAX_QUOT_W-1:0] qx;
  logic                den_zero, sat;
  logic [RATIO_W-1:0]  ratio_fin;
  logic                start, step, emit;

  // operand selection for the channel at work and the one after it
  always_comb begin
    case (ch)
      CH_W'(0): begin
        den      = job.vden;
        num_next = job.inum;
      end
      CH_W'(1): begin
        den      = job.iden;
        num_next = job.pnum;
      end
      default: begin
        den      = job.pden;
        num_next = job.pnum;
      end
    endcase
  end

  // one quotient bit per cycle
  assign trial     = {rem, dvd[QUOT_W-1]};
  assign diff      = trial - {1'b0, den};
  assign ge        = (trial >= {1'b0, den});
  assign rem_step  = ge ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
  assign quot_step = {quot[QUOT_W-2:0], ge};
  assign qx        = MAX_QUOT_W'(quot_step);
  assign sat       = |qx[MAX_QUOT_W-1:RATIO_W];
  assign den_zero  = (den == '0);
  assign ratio_fin = (den_zero || sat) ? RATIO_SAT : qx[RATIO_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) state <= BK_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    start      = 1'b0;
    step       = 1'b0;
    emit       = 1'b0;
    job_ready  = (state == BK_IDLE);
    case (state)
      BK_IDLE: begin
        if (hs.valid) begin
          start      = 1'b1;
          state_next = BK_RUN;
        end
      end
      BK_RUN: begin
        step = 1'b1;
        if ((cnt == '0) && (ch == CH_W'(NUM_CH - 1))) state_next = BK_DONE;
      end
      BK_DONE: begin
        if (!meas.valid || meas.ready) begin
          emit       = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (start) begin
      job  <= job_in;
      ch   <= '0;
      cnt  <= CNT_W'(QUOT_W - 1);
      rem  <= '0;
      dvd  <= QUOT_W'(job_in.vnum) << FRACTION_BITS;
      quot <= '0;
    end else if (step) begin
      if (cnt == '0) begin
        res_ratio[ch] <= ratio_fin;
        res_zero[ch]  <= den_zero;
        ch            <= ch + CH_W'(1);
        cnt           <= CNT_W'(QUOT_W - 1);
        rem           <= '0;
        dvd           <= QUOT_W'(num_next) << FRACTION_BITS;
        quot          <= '0;
      end else begin
        rem  <= rem_step;
        dvd  <= dvd << 1;
        quot <= quot_step;
        cnt  <= cnt - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) meas.valid <= 1'b0;
    else if (emit) meas.valid <= 1'b1;
    else if (meas.ready) meas.valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      meas.voltage_ratio    <= res_ratio[0];
      meas.current_ratio    <= res_ratio[1];
      meas.power_ratio      <= res_ratio[2];
      meas.voltage_den_zero <= res_zero[0];
      meas.current_den_zero <= res_zero[1];
      meas.power_den_zero   <= res_zero[2];
    end
  end

  a_zero_sat: assert property (@(posedge clk) disable iff (rst)
    (meas.valid && meas.voltage_den_zero) |-> (meas.voltage_ratio == RATIO_SAT))
    else $error("zero voltage denominator without saturated ratio");
  a_ch_range: assert property (@(posedge clk) disable iff (rst)
    (state == BK_RUN) |-> (ch <= CH_W'(NUM_CH - 1)))
    else $error("channel index out of range");

endmodule

// ===== hw/rtl/meter_frame_ratio_decoder.sv =====
// meter frame ratio decoder top level: parser, job queue and divider
// throughput: one byte beat per cycle, save a closing beat held while the queue is full;
//   the shared one-bit-per-cycle divider works one frame at a time, two can queue
// reset: synchronous, active high; parser back to hunting, queue empty, no result
module meter_frame_ratio_decoder import mfr_pkg::*; #(
  parameter int FRACTION_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  mfr_byte_if.sink     rx,
  mfr_result_if.source meas
);

  // parser side
  logic      push;
  logic      q_full;
  meas_job_t front_job;

  // divider side
  job_hs_t   q_hs;
  logic      back_ready;
  meas_job_t back_job;

  // sync hunt, 22-byte capture, job handed over on the closing beat
  mfr_front u_front (
    .clk    (clk),
    .rst    (rst),
    .rx     (rx),
    .push   (push),
    .job    (front_job),
    .q_full (q_full)
  );

  // decouples byte intake from the long divisions
  mfr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .job_in    (front_job),
    .full      (q_full),
    .hs        (q_hs),
    .pop_ready (back_ready),
    .job_out   (back_job)
  );

  // voltage, current, power in turn through one divider, then the output register
  mfr_back #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .hs        (q_hs),
    .job_ready (back_ready),
    .job_in    (back_job),
    .meas      (meas)
  );

endmodule

// ===== verif/meter_frame_ratio_decoder_tb.sv =====
// self-checking testbench for the meter frame ratio decoder
module meter_frame_ratio_decoder_tb import mfr_pkg::*; ();

  localparam int FRAC_BITS   = 16;
  localparam int PHASE_BYTES = 300;   // random bytes per idling phase

  // one decoded frame: three quotients and their zero-denominator flags
  typedef struct {
    logic [RATIO_W-1:0] voltage;
    logic [RATIO_W-1:0] current;
    logic [RATIO_W-1:0] power;
    logic               voltage_zero;
    logic               current_zero;
    logic               power_zero;
  } ratio_set_t;

  // tracks the frame parser and holds the ratio sets still owed by the block
  class frame_scoreboard;
    hunt_phase_t       phase;
    int unsigned       pos;
    logic [BYTE_W-1:0] store [STORE_BYTES];
    ratio_set_t        owed_q [$];
    int unsigned       errors;

    function new();
      phase  = PH_HUNT;
      pos    = 0;
      errors = 0;
    endfunction

    function logic [WORD_W-1:0] word_at(int unsigned at);
      return {store[at], store[at+1], store[at+2]};
    endfunction

    // fixed-point quotient, all ones on a zero divisor or on overflow
    function void divide(input logic [WORD_W-1:0] num, input logic [WORD_W-1:0] den,
                         output logic [RATIO_W-1:0] quot, output logic zero);
      logic [63:0] wide;
      if (den == '0) begin
        quot = RATIO_SAT;
        zero = 1'b1;
      end else begin
        wide = ({40'd0, num} << FRAC_BITS) / {40'd0, den};
        quot = (wide > {24'd0, RATIO_SAT}) ? RATIO_SAT : wide[RATIO_W-1:0];
        zero = 1'b0;
      end
    endfunction

    // advance the parser by one accepted byte
    function void note_byte(logic [BYTE_W-1:0] b);
      ratio_set_t r;
      case (phase)
        PH_SYNC2: begin
          phase = (b == SYNC_SECOND) ? PH_CAPTURE : PH_HUNT;
          pos   = 0;
        end
        PH_CAPTURE: begin
          if (pos < STORE_BYTES) store[pos] = b;
          if (pos + 1 < CAPTURE_LEN) begin
            pos++;
          end else begin
            phase = PH_HUNT;
            pos   = 0;
            divide(word_at(0),  word_at(3),  r.voltage, r.voltage_zero);
            divide(word_at(6),  word_at(9),  r.current, r.current_zero);
            divide(word_at(12), word_at(15), r.power,   r.power_zero);
            owed_q.push_back(r);
          end
        end
        default: begin
          phase = (b == SYNC_FIRST) ? PH_SYNC2 : PH_HUNT;
          pos   = 0;
        end
      endcase
    endfunction

    task report_mismatch(string msg);
      $display("ERROR: %s", msg);
      errors++;
    endtask

    task check_result(ratio_set_t got);
      ratio_set_t want;
      if (owed_q.size() == 0) begin
        report_mismatch("result beat with no frame outstanding");
        return;
      end
      want = owed_q.pop_front();
      if (got.voltage !== want.voltage)
        report_mismatch($sformatf("voltage_ratio %h, want %h", got.voltage, want.voltage));
      if (got.current !== want.current)
        report_mismatch($sformatf("current_ratio %h, want %h", got.current, want.current));
      if (got.power !== want.power)
        report_mismatch($sformatf("power_ratio %h, want %h", got.power, want.power));
      if (got.voltage_zero !== want.voltage_zero)
        report_mismatch($sformatf("voltage_den_zero %b, want %b",
                                  got.voltage_zero, want.voltage_zero));
      if (got.current_zero !== want.current_zero)
        report_mismatch($sformatf("current_den_zero %b, want %b",
                                  got.current_zero, want.current_zero));
      if (got.power_zero !== want.power_zero)
        report_mismatch($sformatf("power_den_zero %b, want %b",
                                  got.power_zero, want.power_zero));
    endtask

    function int unsigned pending();
      return owed_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  mfr_byte_if   rx_ch ();
  mfr_result_if meas_ch ();

  meter_frame_ratio_decoder #(.FRACTION_BITS(FRAC_BITS)) dut (
    .clk  (clk),
    .rst  (rst),
    .rx   (rx_ch),
    .meas (meas_ch)
  );

  frame_scoreboard sb = new();

  // idling knobs, changed between phases of the random part
  int unsigned src_idle_pct   = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned bytes_sent     = 0;

  always #2 clk = ~clk;

  // generous hard stop, far beyond the slowest correct run
  initial begin
    #1600000;
    $display("Mismatches found");
    $finish;
  end

  // receiver: ready drops at random in the stalling phases
  always @(posedge clk) begin
    if (rst) begin
      meas_ch.ready <= 1'b0;
    end else begin
      meas_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // result monitor: signals read at the edge are the pre-edge values
  always @(posedge clk) begin
    ratio_set_t got;
    if (!rst && meas_ch.valid && meas_ch.ready) begin
      got.voltage      = meas_ch.voltage_ratio;
      got.current      = meas_ch.current_ratio;
      got.power        = meas_ch.power_ratio;
      got.voltage_zero = meas_ch.voltage_den_zero;
      got.current_zero = meas_ch.current_den_zero;
      got.power_zero   = meas_ch.power_den_zero;
      sb.check_result(got);
    end
  end

  // one byte beat, with a random gap ahead of it when the sender idles;
  // valid stays high between back-to-back beats
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    if ($urandom_range(99) < src_idle_pct) begin
      rx_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    do @(posedge clk); while (!rx_ch.ready);
    sb.note_byte(b);
    bytes_sent++;
  endtask

  // big-endian 24-bit field
  task automatic send_word(input logic [WORD_W-1:0] w);
    send_byte(w[23:16]);
    send_byte(w[15:8]);
    send_byte(w[7:0]);
  endtask

  // complete frame: sync pair, six fields, four trailing checksum bytes
  task automatic send_frame(input logic [WORD_W-1:0] vnum, input logic [WORD_W-1:0] vden,
                            input logic [WORD_W-1:0] inum, input logic [WORD_W-1:0] iden,
                            input logic [WORD_W-1:0] pnum, input logic [WORD_W-1:0] pden);
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    send_word(vnum);
    send_word(vden);
    send_word(inum);
    send_word(iden);
    send_word(pnum);
    send_word(pden);
    repeat (4) send_byte(8'($urandom));
  endtask

  // field values biased toward zero, one, small and full scale
  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return 24'd1;
      3:       return WORD_W'($urandom_range(255, 2));
      default: return WORD_W'($urandom);
    endcase
  endfunction

  // random traffic for one idling phase: mostly good frames, some noise
  task automatic random_phase(input int unsigned idle_pct, input int unsigned stall_pct);
    int unsigned stop_at;
    stop_at        = bytes_sent + PHASE_BYTES;
    src_idle_pct   = idle_pct;
    sink_stall_pct = stall_pct;
    while (bytes_sent < stop_at) begin
      case ($urandom_range(9))
        0: begin
          // broken sync: first sync byte followed by anything but the second
          send_byte(SYNC_FIRST);
          send_byte(($urandom_range(1) == 0) ? SYNC_FIRST : 8'($urandom_range(255, 91)));
        end
        1: begin
          repeat ($urandom_range(6, 1)) send_byte(8'($urandom));
        end
        default: begin
          send_frame(pick_word(), pick_word(), pick_word(),
                     pick_word(), pick_word(), pick_word());
        end
      endcase
    end
  endtask

  initial begin
    rx_ch.valid   <= 1'b0;
    rx_ch.rx_byte <= '0;
    rst           <= 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed part, no idling
    // noise at both byte extremes while hunting
    send_byte(8'h00);
    send_byte(8'hFF);
    // wrong second sync, even a repeated first sync byte, drops back to hunting
    send_byte(SYNC_FIRST);
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    send_byte(SYNC_FIRST);
    send_byte(8'h00);
    // largest quotient, zero numerator, full-scale over full-scale
    send_frame('1, 24'd1, '0, '1, '1, '1);
    // every denominator zero
    send_frame(24'h123456, '0, '1, '0, '0, '0);
    // only the voltage denominator zero, small nonzero other denominators
    send_frame(24'd7, '0, 24'd1, 24'd3, 24'h800000, 24'd2);

    // random part across the idling phases
    random_phase(0, 0);
    random_phase(57, 0);
    random_phase(0, 57);
    random_phase(10, 10);

    // drop valid after the last beat, wait out the queue plus one latency
    rx_ch.valid <= 1'b0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (3 * (WORD_W + FRAC_BITS) + 40) @(posedge clk);

    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
